@@ sv/ciq_pkg.sv @@
// Shared types and constants for the costmap inflation query block.
// No dependencies; every other file refers to this package by scoped names.
package ciq_pkg;

    // Operation codes of an input word
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Register indexes on the configuration port (paddr[3:2])
    localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [1:0] REG_OCC_THRESH  = 2'd2;
    localparam logic [1:0] REG_RADIUS      = 2'd3;

    // Reset values of the registers
    localparam logic [8:0] RST_GRID_WIDTH  = 9'd256;
    localparam logic [8:0] RST_GRID_HEIGHT = 9'd256;
    localparam logic [6:0] RST_OCC_THRESH  = 7'd65;
    localparam logic [3:0] RST_RADIUS      = 4'd0;

    // Width of a signed neighbor coordinate (cell coordinate plus offset)
    localparam int SCW = 10;

    typedef struct packed {
        logic              operation;
        logic [7:0]        cell_x;
        logic [7:0]        cell_y;
        logic signed [7:0] occupancy;
    } t_in_word;

    typedef struct packed {
        logic blocked;
        logic outside_map;
    } t_out_word;

    typedef struct packed {
        logic [8:0] grid_width;
        logic [8:0] grid_height;
        logic [6:0] occ_thresh;
        logic [3:0] radius;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic load_wr;   // write the accepted load word into the grid
        logic q_start;   // capture the accepted query word, reset the walk
        logic walk;      // issue one disk probe and advance the offsets
        logic out_load;  // load the result register
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_outside;  // incoming word lies outside the map in use
        logic walk_last;   // current probe is the last cell of the square
    } t_dp_stat;

endpackage

@@ sv/costmap_inflation_query_top.sv @@
// Top level of the costmap inflation query block: configuration registers,
// APB-style port, controller and datapath. Depends on ciq_pkg, ciq_ctrl, ciq_datapath.
//
//  channel  | signals                          | transfer
//  ---------+----------------------------------+--------------------------------
//  input    | start, busy, i_in                | start && !busy at the clock edge
//  result   | o_done, o_out                    | o_done high for one cycle
//  config   | psel/penable/pwrite/paddr/pwdata | access phase, pready always high
//
// A load needs no walk; busy stays low and the next word may follow at once.
// A query outside the map goes straight to the result state; one inside the map walks the
// (2r+1)^2 square around the cell, one grid-memory read per cycle, then drains through the
// probe, read data and hit registers before its result: the single read port sets the rate.
// Reset is synchronous and resets the configuration registers and control state; the grid is not cleared.
// The receiver cannot stall: o_done marks each result word for one cycle only.
module costmap_inflation_query_top #(
    parameter int MAX_WIDTH    = 256,
    parameter int MAX_HEIGHT   = 256,
    parameter int RADIUS_LIMIT = 15
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  ciq_pkg::t_in_word  i_in,
    output logic               o_done,
    output ciq_pkg::t_out_word o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // Configuration registers
    logic [8:0] r_grid_width, r_grid_height;
    logic [6:0] r_occ_thresh;
    logic [3:0] r_radius;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= ciq_pkg::RST_GRID_WIDTH;
            r_grid_height <= ciq_pkg::RST_GRID_HEIGHT;
            r_occ_thresh  <= ciq_pkg::RST_OCC_THRESH;
            r_radius      <= ciq_pkg::RST_RADIUS;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                ciq_pkg::REG_GRID_WIDTH:  r_grid_width  <= pwdata[8:0];
                ciq_pkg::REG_GRID_HEIGHT: r_grid_height <= pwdata[8:0];
                ciq_pkg::REG_OCC_THRESH:  r_occ_thresh  <= pwdata[6:0];
                ciq_pkg::REG_RADIUS:      r_radius      <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (paddr[3:2])
            ciq_pkg::REG_GRID_WIDTH:  prdata = {23'd0, r_grid_width};
            ciq_pkg::REG_GRID_HEIGHT: prdata = {23'd0, r_grid_height};
            ciq_pkg::REG_OCC_THRESH:  prdata = {25'd0, r_occ_thresh};
            ciq_pkg::REG_RADIUS:      prdata = {28'd0, r_radius};
            default:                  prdata = 32'd0;
        endcase
    end

    ciq_pkg::t_cfg      cfg;
    ciq_pkg::t_ctrl_cmd cmd;
    ciq_pkg::t_dp_stat  stat;
    logic               accept;

    assign cfg.grid_width  = r_grid_width;
    assign cfg.grid_height = r_grid_height;
    assign cfg.occ_thresh  = r_occ_thresh;
    assign cfg.radius      = r_radius;
    assign accept          = start && !busy;

    ciq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_operation (i_in.operation),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_busy      (busy),
        .o_done      (o_done)
    );

    ciq_datapath #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .RADIUS_LIMIT (RADIUS_LIMIT)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_out   (o_out)
    );

endmodule

@@ sv/ciq_ctrl.sv @@
// Sequencer for the costmap inflation query block: idle, disk walk, drain, result.
// Depends on ciq_pkg.
module ciq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_operation,
    input  ciq_pkg::t_dp_stat i_stat,
    output ciq_pkg::t_ctrl_cmd o_cmd,
    output logic              o_busy,
    output logic              o_done
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_WALK   = 5'b00010,
        S_DRAIN1 = 5'b00100,
        S_DRAIN2 = 5'b01000,
        S_RESULT = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_done, n_done;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    if (i_operation == ciq_pkg::OP_QUERY) begin
                        o_cmd.q_start = 1'b1;
                        n_state = i_stat.in_outside ? S_RESULT : S_WALK;
                    end else begin
                        o_cmd.load_wr = 1'b1;
                    end
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_stat.walk_last) begin
                    n_state = S_DRAIN1;
                end
            end
            // probe register -> read data register -> hit flag
            S_DRAIN1: n_state = S_DRAIN2;
            S_DRAIN2: n_state = S_RESULT;
            S_RESULT: begin
                o_cmd.out_load = 1'b1;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

@@ sv/ciq_datapath.sv @@
// Datapath of the costmap inflation query block: obstacle grid memory,
// disk offset counters, probe address pipeline, hit flag and result register.
// Depends on ciq_pkg.
module ciq_datapath #(
    parameter int MAX_WIDTH    = 256,
    parameter int MAX_HEIGHT   = 256,
    parameter int RADIUS_LIMIT = 15
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ciq_pkg::t_cfg      i_cfg,
    input  ciq_pkg::t_in_word  i_in,
    input  ciq_pkg::t_ctrl_cmd i_cmd,
    output ciq_pkg::t_dp_stat  o_stat,
    output ciq_pkg::t_out_word o_out
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW    = (RADIUS_LIMIT > 0) ? $clog2(RADIUS_LIMIT + 1) : 1;
    localparam int SQW   = 2 * RW + 1;
    localparam int SCW   = ciq_pkg::SCW;

    // Obstacle grid, one bit per cell at row*MAX_WIDTH + column
    logic mem_bits [DEPTH];

    // Map size and radius in use (saturated to the maximums)
    logic [8:0]    used_w, used_h;
    logic [RW-1:0] used_r;

    assign used_w = (int'(i_cfg.grid_width) > MAX_WIDTH) ? 9'(MAX_WIDTH) : i_cfg.grid_width;
    assign used_h = (int'(i_cfg.grid_height) > MAX_HEIGHT) ? 9'(MAX_HEIGHT)
                                                          : i_cfg.grid_height;
    assign used_r = (int'(i_cfg.radius) > RADIUS_LIMIT) ? RW'(RADIUS_LIMIT)
                                                        : RW'(i_cfg.radius);

    // Incoming word checks
    logic          in_outside, in_obst;
    logic [AW-1:0] in_addr;

    assign in_outside = ({1'b0, i_in.cell_x} >= used_w) || ({1'b0, i_in.cell_y} >= used_h);
    assign in_obst    = i_in.occupancy[7] || (i_in.occupancy[6:0] >= i_cfg.occ_thresh);
    assign in_addr    = AW'(32'(i_in.cell_y) * MAX_WIDTH + 32'(i_in.cell_x));

    // Query context and walk offsets
    logic [7:0]           r_x, r_y;
    logic [RW-1:0]        r_r;
    logic [SQW-1:0]       r_rsq;
    logic                 r_outside;
    logic signed [RW:0]   r_dx, r_dy, n_dx, n_dy;
    logic signed [RW:0]   rad_pos, rad_neg;
    logic                 walk_last;

    assign rad_pos = $signed({1'b0, r_r});
    assign rad_neg = -rad_pos;
    assign walk_last = (r_dx == rad_pos) && (r_dy == rad_pos);

    // Raster step over the (2r+1) square
    always_comb begin
        if (r_dx == rad_pos) begin
            n_dx = rad_neg;
            n_dy = r_dy + (RW+1)'(1);
        end else begin
            n_dx = r_dx + (RW+1)'(1);
            n_dy = r_dy;
        end
    end

    // Probe: disk test, map bounds, address
    logic [RW-1:0]          mag_x, mag_y;
    logic [SQW-1:0]         dist_sq;
    logic signed [SCW-1:0]  nx, ny;
    logic                   probe_ok;
    logic [AW-1:0]          probe_addr;

    assign mag_x   = r_dx[RW] ? RW'(-r_dx) : RW'(r_dx);
    assign mag_y   = r_dy[RW] ? RW'(-r_dy) : RW'(r_dy);
    assign dist_sq = SQW'(mag_x) * SQW'(mag_x) + SQW'(mag_y) * SQW'(mag_y);
    assign nx      = $signed({(SCW-8)'(0), r_x}) + SCW'(r_dx);
    assign ny      = $signed({(SCW-8)'(0), r_y}) + SCW'(r_dy);
    assign probe_ok = (dist_sq <= r_rsq)
                   && !nx[SCW-1] && (nx[8:0] < used_w)
                   && !ny[SCW-1] && (ny[8:0] < used_h);
    assign probe_addr = AW'(32'(ny[7:0]) * MAX_WIDTH + 32'(nx[7:0]));

    // Query context registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.q_start) begin
            r_x       <= i_in.cell_x;
            r_y       <= i_in.cell_y;
            r_r       <= used_r;
            r_rsq     <= SQW'(used_r) * SQW'(used_r);
            r_dx      <= -$signed({1'b0, used_r});
            r_dy      <= -$signed({1'b0, used_r});
            r_outside <= in_outside;
        end else if (i_cmd.walk) begin
            r_dx <= n_dx;
            r_dy <= n_dy;
        end
    end

    // Probe and read pipeline
    logic [AW-1:0] r_addr;
    logic          r_pvld, r_rd_vld, r_rd_data, r_hit;

    always_ff @(posedge i_clk) begin
        r_addr <= probe_addr;
        if (!i_rst_n) begin
            r_pvld   <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_pvld   <= i_cmd.walk && probe_ok;
            r_rd_vld <= r_pvld;
        end
    end

    // Grid memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && !in_outside) begin
            mem_bits[in_addr] <= in_obst;
        end
        r_rd_data <= mem_bits[r_addr];
    end

    // Hit flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.q_start) begin
            r_hit <= 1'b0;
        end else if (r_rd_vld && r_rd_data) begin
            r_hit <= 1'b1;
        end
    end

    // Result register
    ciq_pkg::t_out_word r_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.blocked     <= r_outside || r_hit;
            r_out.outside_map <= r_outside;
        end
    end

    assign o_out             = r_out;
    assign o_stat.in_outside = in_outside;
    assign o_stat.walk_last  = walk_last;

endmodule

@@ sv/ciq_checker.sv @@
// Port-level checks for the costmap inflation query block, bound to the top level.
// Depends on ciq_pkg and costmap_inflation_query_top.
module ciq_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input ciq_pkg::t_in_word  i_in,
    input logic               o_done,
    input ciq_pkg::t_out_word o_out
);

    // a result word is never followed directly by another
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held two cycles");

    // an outside cell is always reported blocked
    a_outside_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_out.outside_map) |-> o_out.blocked)
        else $error("outside cell not blocked");

    // an accepted query keeps the block busy in the next cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_in.operation == ciq_pkg::OP_QUERY) |=> busy)
        else $error("query accepted without going busy");

    // a load leaves the block free for the next word
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_in.operation == ciq_pkg::OP_LOAD) |=> !busy && !o_done)
        else $error("load blocked the input or produced a result");

    // the block is idle while a result word is shown
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while busy");

endmodule

bind costmap_inflation_query_top ciq_checker u_ciq_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_in    (i_in),
    .o_done  (o_done),
    .o_out   (o_out)
);
